// ===== hdl/mpl_pkg.sv =====
// Shared constants and float compare helpers for the max pooling line buffer.
package mpl_pkg;
  localparam int LINE_WIDTH_MAX_DEF = 256;
  localparam int WINDOW_MAX_DEF = 8;
  localparam logic [31:0] NEG_INF_BITS = 32'hFF80_0000;
  localparam logic [12:0] HEIGHT_LIMIT = 13'd4096;

  localparam logic [1:0] REG_SIZE   = 2'd0;
  localparam logic [1:0] REG_STRIDE = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_WIDTH  = 2'd3;

  function automatic logic [31:0] order_key(input logic [31:0] x);
    order_key = x[31] ? ~x : (x | 32'h8000_0000);
  endfunction

  // a > b as floats; b is never NaN
  function automatic logic float_greater(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic both_zero;
    a_nan = (a[30:0] > 31'h7F80_0000);
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    float_greater = !a_nan && !both_zero && (order_key(a) > order_key(b));
  endfunction
endpackage

// ===== hdl/mpl_store.sv =====
// Line store: one-write, one-read synchronous memory with registered read data.
module mpl_store #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [31:0]              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [31:0]              rd_data
);
  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== hdl/max_pool_2d_line_buffer_unit.sv =====
// Top level of the max pooling line buffer: counters, window scan and stream ports.
//
// Pixels arrive in raster order on the s_axis side; each is written into a line
// store of WINDOW_MAX rows by LINE_WIDTH_MAX columns held in one synchronous memory.
// A pixel that is the bottom-right corner of a stride-aligned window starts a
// scan that reads the window_size by window_size entries through the single
// read port, one entry a cycle, newest row first and left to right, keeping a
// running float maximum that starts at minus infinity (NaN never wins). A pixel
// that closes no window leaves the unit ready for the next pixel; one that closes
// a window goes through the accept, a read per entry, a step to fold in the last
// read data, a step to close the scan and one to load the output register. The
// result waits in an output register, and the next pixel is taken while it waits;
// a second result stalls the input until the first is taken.
// Any write to a register index 0..3 restarts the frame counters; other indexes
// are ignored. No clearing pass: entries are read only after being written.
module max_pool_2d_line_buffer_unit #(
  parameter int LINE_WIDTH_MAX = mpl_pkg::LINE_WIDTH_MAX_DEF,
  parameter int WINDOW_MAX = mpl_pkg::WINDOW_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] pixel_bits
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] window_max_bits
);
  import mpl_pkg::*;

  localparam int CW = $clog2(LINE_WIDTH_MAX);
  localparam int SW = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
  localparam int AW = $clog2(WINDOW_MAX * LINE_WIDTH_MAX);
  localparam int KW = $clog2(WINDOW_MAX + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;
  logic [3:0]  window_size;
  logic [7:0]  window_stride;
  logic [12:0] frame_height;
  logic [8:0]  frame_width;

  logic [11:0] row_index;
  logic [CW:0] column_index;
  logic [SW-1:0] row_slot;

  // scan state
  logic [KW-1:0] scan_i, scan_j;
  logic [CW:0]   scan_col0;
  logic [SW-1:0] scan_slot;
  logic          rd_pend;
  logic          scan_last;
  logic [31:0]   best;

  // effective settings
  logic [KW-1:0] ws;
  logic [7:0]    st;
  logic [12:0]   h;
  logic [CW:0]   w;

  always_comb begin
    if (window_size == 4'd0) ws = KW'(1);
    else if (32'(window_size) > WINDOW_MAX) ws = KW'(WINDOW_MAX);
    else ws = KW'(window_size);
    st = (window_stride == 8'd0) ? 8'd1 : window_stride;
    if (frame_height == 13'd0) h = 13'd1;
    else if (frame_height > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    else h = frame_height;
    if (frame_width == 9'd0) w = (CW+1)'(1);
    else if (32'(frame_width) > LINE_WIDTH_MAX) w = (CW+1)'(LINE_WIDTH_MAX);
    else w = (CW+1)'(frame_width);
  end

  // Stride phase counters replace the modulo: reset at window edge, wrap at stride.
  logic [7:0] row_phase, col_phase;

  logic          accept;
  logic          hit;
  logic [11:0]   r_cur;
  logic [CW:0]   c_cur;
  logic [SW-1:0] slot_cur;
  logic [7:0]    rph_cur, cph_cur;
  logic          out_full;
  logic          out_load;

  assign cfg_ready = (state == ST_IDLE);
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign accept = s_axis_tvalid && s_axis_tready;
  // load the output register once it is free or being drained this cycle
  assign out_load = (state == ST_DONE) && (!out_full || m_axis_tready);

  always_comb begin
    r_cur = row_index;
    c_cur = column_index;
    slot_cur = row_slot;
    rph_cur = row_phase;
    cph_cur = col_phase;
    if (c_cur >= w || {1'b0, r_cur} >= h || KW'(slot_cur) >= ws) begin
      r_cur = '0; c_cur = '0; slot_cur = '0; rph_cur = '0; cph_cur = '0;
    end
    hit = (32'(r_cur) >= 32'(ws) - 1) && (32'(c_cur) >= 32'(ws) - 1)
          && rph_cur == 8'd0 && cph_cur == 8'd0;
  end

  // phase: counts from 0 once the index reaches ws-1, wraps at stride
  function automatic logic [7:0] next_phase(input logic [31:0] idx, input logic [7:0] ph,
                                            input logic [KW-1:0] wsz, input logic [7:0] s);
    if (idx < 32'(wsz) - 1) next_phase = 8'd0;
    else if (ph + 8'd1 == s) next_phase = 8'd0;
    else next_phase = ph + 8'd1;
  endfunction

  // memory
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [31:0]   rd_data;
  logic [CW:0]   rd_col;

  assign wr_en = accept;
  assign wr_addr = AW'(32'(slot_cur) * LINE_WIDTH_MAX + 32'(c_cur[CW-1:0]));
  assign rd_col = scan_col0 + (CW+1)'(scan_j);
  assign rd_en = (state == ST_SCAN) && !scan_last;
  assign rd_addr = AW'(32'(scan_slot) * LINE_WIDTH_MAX + 32'(rd_col[CW-1:0]));

  mpl_store #(.DEPTH(WINDOW_MAX * LINE_WIDTH_MAX)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(s_axis_tdata),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      window_size <= 4'd2; window_stride <= 8'd2;
      frame_height <= 13'd256; frame_width <= 9'd256;
      row_index <= '0; column_index <= '0; row_slot <= '0;
      row_phase <= '0; col_phase <= '0;
      out_full <= 1'b0; rd_pend <= 1'b0; scan_last <= 1'b0;
    end else begin
      if (out_load) out_full <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_full <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              REG_SIZE:   window_size <= cfg_data[3:0];
              REG_STRIDE: window_stride <= cfg_data[7:0];
              REG_HEIGHT: frame_height <= cfg_data;
              REG_WIDTH:  frame_width <= cfg_data[8:0];
              default: ;
            endcase
            // restart the frame
            row_index <= '0; column_index <= '0; row_slot <= '0;
            row_phase <= '0; col_phase <= '0;
          end else if (accept) begin
            // advance counters
            if (c_cur + 1'b1 >= w) begin
              column_index <= '0;
              col_phase <= '0;
              if ({1'b0, r_cur} + 13'd1 >= h) begin
                row_index <= '0; row_slot <= '0; row_phase <= '0;
              end else begin
                row_index <= r_cur + 12'd1;
                row_slot <= (KW'(slot_cur) + 1'b1 >= ws) ? '0 : slot_cur + 1'b1;
                row_phase <= next_phase(32'(r_cur), rph_cur, ws, st);
              end
            end else begin
              column_index <= c_cur + 1'b1;
              col_phase <= next_phase(32'(c_cur), cph_cur, ws, st);
              row_index <= r_cur; row_slot <= slot_cur; row_phase <= rph_cur;
            end
            if (hit) begin
              state <= ST_SCAN;
              scan_i <= '0; scan_j <= '0;
              scan_slot <= slot_cur;
              scan_col0 <= c_cur - (CW+1)'(ws) + 1'b1;
              best <= NEG_INF_BITS;
              rd_pend <= 1'b0; scan_last <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          rd_pend <= rd_en;
          if (rd_pend && float_greater(rd_data, best)) best <= rd_data;
          if (rd_en) begin
            if (scan_j + 1'b1 == ws) begin
              scan_j <= '0;
              scan_slot <= (scan_slot == '0) ? SW'(ws - 1'b1) : scan_slot - 1'b1;
              if (scan_i + 1'b1 == ws) scan_last <= 1'b1;
              else scan_i <= scan_i + 1'b1;
            end else begin
              scan_j <= scan_j + 1'b1;
            end
          end else if (!rd_pend) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            m_axis_tdata <= best;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_full;
endmodule
